@@ hdl/pbst_pkg.sv @@
// ----------------------------------------------------------------------------
// pbst_pkg - piece block state tracker shared definitions
// Request codes, block states, result codes, register map and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pbst_pkg;

    // request codes
    localparam logic [2:0] REQ_BLOCK   = 3'd0;
    localparam logic [2:0] REQ_ARRIVE  = 3'd1;
    localparam logic [2:0] REQ_SWEEP   = 3'd2;
    localparam logic [2:0] REQ_ALLFULL = 3'd3;
    localparam logic [2:0] REQ_PASS    = 3'd4;
    localparam logic [2:0] REQ_FAIL    = 3'd5;

    // block states
    localparam logic [1:0] BS_FREE    = 2'd0;
    localparam logic [1:0] BS_PENDING = 2'd1;
    localparam logic [1:0] BS_FULL    = 2'd2;

    // result status
    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_NONE  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    // register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_PIECE_LEN = 2'd0;
    localparam logic [1:0] REG_TOTAL_LEN = 2'd1;
    localparam logic [1:0] REG_PIECE_CNT = 2'd2;
    localparam logic [1:0] REG_TIMEOUT   = 2'd3;

    localparam logic [20:0] PIECE_LEN_RESET = 21'd262144;
    localparam logic [39:0] TOTAL_LEN_RESET = 40'd0;
    localparam logic [8:0]  PIECE_CNT_RESET = 9'd1;
    localparam logic [7:0]  TIMEOUT_RESET   = 8'd5;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 64;
    localparam int IN_DW  = 64;
    localparam int IN_UW  = 3;
    localparam int OUT_DW = 24;

    typedef struct packed {
        logic [20:0] piece_size;
        logic [39:0] total_length;
        logic [8:0]  piece_count;
        logic [7:0]  timeout_seconds;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic size;
        logic early;
        logic walk_init;
        logic walk_en;
        logic push;
        logic clr_en;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic early;
        logic walk_stop;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

@@ hdl/piece_block_state_tracker.sv @@
// ----------------------------------------------------------------------------
// piece_block_state_tracker - per-piece block request tracker
// Keeps free/pending/full state and request time per block, plus a
// complete flag per piece, and serves request, arrival, sweep, all-full,
// verify-pass and verify-fail commands.
// Input stream s_*: one command per transfer, command code on s_tuser.
// Result stream m_*: exactly one result per command, in order.
// Config: APB-style, 64-bit data, register i at byte address 8*i; write it
// only while no command is in flight.
// After reset a clearing pass writes every block entry, one per cycle,
// NUM_PIECES*MAX_BLOCKS entries (16384 at the defaults); s_tready
// stays low meanwhile.
// One command at a time. Verify-pass, unknown and out-of-range commands
// and requests on a complete piece skip the walk; walking commands examine
// one block per cycle through the block state table's read port, where a
// walk that runs off the piece examines one slot past its last block.
// The result waits in an output register while m_tready is low; the next
// command is accepted and processed meanwhile and holds its result
// internally until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module piece_block_state_tracker #(
    parameter int NUM_PIECES  = 256,
    parameter int MAX_BLOCKS  = 64,
    parameter int BLOCK_BYTES = 16384
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // s_tdata: piece_number[7:0], byte_offset[27:8], now_seconds[59:28]
    input  wire logic [pbst_pkg::IN_DW-1:0]  s_tdata,
    // s_tuser: req_type[2:0]
    input  wire logic [pbst_pkg::IN_UW-1:0]  s_tuser,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // m_tdata: status[1:0], granted_block[7:2], granted_length[22:8],
    //          piece_all_full[23]
    output logic      [pbst_pkg::OUT_DW-1:0] m_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pbst_pkg::CFG_AW-1:0] paddr,
    input  wire logic [pbst_pkg::CFG_DW-1:0] pwdata,
    output logic      [pbst_pkg::CFG_DW-1:0] prdata,
    output logic                             pready
);

    pbst_pkg::cfg_t  cfg;
    pbst_pkg::cmd_t  cmd;
    pbst_pkg::stat_t stat;

    pbst_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbst_dp #(
        .NUM_PIECES  (NUM_PIECES),
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // one command in flight: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a command is in flight");

    // out-of-range results carry no grant and no full flag
    a_range_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == pbst_pkg::STS_RANGE)) |-> (m_tdata[23:2] == '0))
        else $error("out-of-range result carries payload");

    // a granted length only comes with a done status
    a_grant_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[22:8] != '0)) |-> (m_tdata[1:0] == pbst_pkg::STS_DONE))
        else $error("grant with non-done status");

endmodule

`default_nettype wire

@@ hdl/pbst_regs.sv @@
// ----------------------------------------------------------------------------
// pbst_regs - configuration register file
// APB-style slave holding piece length, total length, piece count and timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module pbst_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pbst_pkg::CFG_AW-1:0] paddr,
    input  wire logic [pbst_pkg::CFG_DW-1:0] pwdata,
    output logic      [pbst_pkg::CFG_DW-1:0] prdata,
    output logic                             pready,
    output pbst_pkg::cfg_t                   cfg
);

    pbst_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.piece_size      <= pbst_pkg::PIECE_LEN_RESET;
            cfg_reg.total_length    <= pbst_pkg::TOTAL_LEN_RESET;
            cfg_reg.piece_count     <= pbst_pkg::PIECE_CNT_RESET;
            cfg_reg.timeout_seconds <= pbst_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                pbst_pkg::REG_PIECE_LEN: cfg_reg.piece_size      <= pwdata[20:0];
                pbst_pkg::REG_TOTAL_LEN: cfg_reg.total_length    <= pwdata[39:0];
                pbst_pkg::REG_PIECE_CNT: cfg_reg.piece_count     <= pwdata[8:0];
                pbst_pkg::REG_TIMEOUT:   cfg_reg.timeout_seconds <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pbst_pkg::REG_PIECE_LEN: prdata = 64'(cfg_reg.piece_size);
            pbst_pkg::REG_TOTAL_LEN: prdata = 64'(cfg_reg.total_length);
            pbst_pkg::REG_PIECE_CNT: prdata = 64'(cfg_reg.piece_count);
            pbst_pkg::REG_TIMEOUT:   prdata = 64'(cfg_reg.timeout_seconds);
            default:                 prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/pbst_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbst_ctrl - sequencing state machine
// Clears the block state and piece-done tables after reset, then per transfer
// steps through piece size calculation, an optional block walk and the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbst_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire pbst_pkg::stat_t stat,
    output pbst_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_WALK,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC1;
                end
            end
            ST_CALC1: begin
                cmd.calc   = 1'b1;
                state_next = ST_CALC2;
            end
            ST_CALC2: begin
                cmd.size = 1'b1;
                if (stat.early) begin
                    cmd.early  = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walk_en = 1'b1;
                if (stat.walk_stop) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!stat.out_busy) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/pbst_dp.sv @@
// ----------------------------------------------------------------------------
// pbst_dp - tracker datapath
// Block state, request time and piece-done tables, piece size arithmetic,
// a two-stage block walker (read, then evaluate/write) and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pbst_dp #(
    parameter int NUM_PIECES  = 256,
    parameter int MAX_BLOCKS  = 64,
    parameter int BLOCK_BYTES = 16384
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pbst_pkg::cfg_t              cfg,
    input  wire logic [pbst_pkg::IN_DW-1:0]  s_tdata,
    input  wire logic [pbst_pkg::IN_UW-1:0]  s_tuser,
    input  wire pbst_pkg::cmd_t              cmd,
    output pbst_pkg::stat_t                  stat,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [pbst_pkg::OUT_DW-1:0] m_tdata
);

    localparam int DEPTH = NUM_PIECES * MAX_BLOCKS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (NUM_PIECES > 1) ? $clog2(NUM_PIECES) : 1;
    localparam int PCW   = $clog2(NUM_PIECES + 1);
    localparam int PRW   = PCW + 21;
    localparam int IW    = $clog2(MAX_BLOCKS + 1);
    localparam int SW    = $clog2(MAX_BLOCKS * BLOCK_BYTES + 1);
    localparam int LW    = $clog2(BLOCK_BYTES + 1);

    // tables
    logic [1:0]  bs_mem [DEPTH];
    logic [31:0] tm_mem [DEPTH];
    logic        pd_mem [NUM_PIECES];

    // captured item
    logic [2:0]  type_reg;
    logic [7:0]  p_reg;
    logic [19:0] off_reg;
    logic [31:0] now_reg;

    // piece geometry
    logic [PCW-1:0] pc;
    logic [PRW-1:0] prod;
    logic           oor_reg;
    logic           last_reg;
    logic [PRW-1:0] before_reg;
    logic [AW-1:0]  base_reg;
    logic [39:0]    size_reg;
    logic [39:0]    size_next;
    logic           pd_rd_reg;
    logic           p_in;
    logic [PW-1:0]  p_idx;

    // early result
    logic           type_bad;
    logic           early;
    logic [1:0]     early_status;
    logic           mark_done;

    // walker stage A
    logic [IW-1:0]  i_reg;
    logic [SW-1:0]  start_reg;
    logic           exists_a;
    logic [AW-1:0]  rd_addr;

    // walker stage B
    logic           valid_d_reg;
    logic           exists_d_reg;
    logic [IW-1:0]  i_d_reg;
    logic [SW-1:0]  start_d_reg;
    logic [AW-1:0]  addr_d_reg;
    logic [1:0]     st_rd_reg;
    logic [31:0]    tm_rd_reg;

    logic           ev_stop;
    logic           ev_wr;
    logic           ev_tm_wr;
    logic [1:0]     ev_st;
    logic [31:0]    ev_tm;
    logic [1:0]     ev_status;
    logic           ev_grant;
    logic           ev_allfull;
    logic [39:0]    rem;
    logic [LW-1:0]  blen;
    logic [31:0]    age;
    logic           in_block;
    logic           eval_en;

    // clearing pass
    logic [AW-1:0]  clr_cnt_reg;
    logic           clr_last;

    // table write ports
    logic           bs_we;
    logic [AW-1:0]  bs_waddr;
    logic [1:0]     bs_wdata;
    logic           pd_we;
    logic [PW-1:0]  pd_waddr;
    logic           pd_wdata;

    // result and output registers
    logic [1:0]     res_status_reg;
    logic [5:0]     res_block_reg;
    logic [14:0]    res_len_reg;
    logic           res_allfull_reg;
    logic           m_tvalid_reg;
    logic [1:0]     out_status_reg;
    logic [5:0]     out_block_reg;
    logic [14:0]    out_len_reg;
    logic           out_allfull_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            type_reg <= s_tuser;
            p_reg    <= s_tdata[7:0];
            off_reg  <= s_tdata[27:8];
            now_reg  <= s_tdata[59:28];
        end
    end

    // ---- piece geometry ----
    always_comb begin
        if (cfg.piece_count == 9'd0) begin
            pc = PCW'(1);
        end else if (32'(cfg.piece_count) > 32'(NUM_PIECES)) begin
            pc = PCW'(NUM_PIECES);
        end else begin
            pc = PCW'(cfg.piece_count);
        end
    end

    assign prod  = PRW'(pc - PCW'(1)) * PRW'(cfg.piece_size);
    assign p_in  = 32'(p_reg) < 32'(NUM_PIECES);
    assign p_idx = PW'(p_reg);

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            oor_reg    <= 32'(p_reg) >= 32'(pc);
            last_reg   <= (32'(p_reg) + 32'd1) >= 32'(pc);
            before_reg <= prod;
            base_reg   <= AW'(32'(p_reg) * 32'(MAX_BLOCKS));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc && p_in) begin
            pd_rd_reg <= pd_mem[p_idx];
        end
    end

    always_comb begin
        if (!last_reg) begin
            size_next = 40'(cfg.piece_size);
        end else if (41'(cfg.total_length) > 41'(before_reg)) begin
            size_next = cfg.total_length - 40'(before_reg);
        end else begin
            size_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.size) begin
            size_reg <= size_next;
        end
    end

    // ---- requests that need no walk ----
    assign type_bad = type_reg > pbst_pkg::REQ_FAIL;
    assign early    = type_bad || oor_reg || (type_reg == pbst_pkg::REQ_PASS) ||
                      ((type_reg == pbst_pkg::REQ_BLOCK) && pd_rd_reg);
    assign mark_done = cmd.early && !type_bad && !oor_reg &&
                       (type_reg == pbst_pkg::REQ_PASS);

    always_comb begin
        if (type_bad) begin
            early_status = pbst_pkg::STS_NONE;
        end else if (oor_reg) begin
            early_status = pbst_pkg::STS_RANGE;
        end else if (type_reg == pbst_pkg::REQ_PASS) begin
            early_status = pbst_pkg::STS_DONE;
        end else begin
            early_status = pbst_pkg::STS_NONE;
        end
    end

    // ---- walker stage A: issue reads ----
    assign exists_a = (i_reg < IW'(MAX_BLOCKS)) && (40'(start_reg) < size_reg);
    assign rd_addr  = base_reg + AW'(i_reg);

    always_ff @(posedge aclk) begin
        if (cmd.walk_init) begin
            i_reg     <= '0;
            start_reg <= '0;
        end else if (cmd.walk_en && exists_a) begin
            i_reg     <= i_reg + IW'(1);
            start_reg <= start_reg + SW'(BLOCK_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_d_reg <= 1'b0;
        end else if (cmd.walk_init) begin
            valid_d_reg <= 1'b0;
        end else begin
            valid_d_reg <= cmd.walk_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_en) begin
            exists_d_reg <= exists_a;
            i_d_reg      <= i_reg;
            start_d_reg  <= start_reg;
            addr_d_reg   <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_en && exists_a) begin
            st_rd_reg <= bs_mem[rd_addr];
            tm_rd_reg <= tm_mem[rd_addr];
        end
    end

    // ---- walker stage B: evaluate one block ----
    assign rem      = size_reg - 40'(start_d_reg);
    assign blen     = (rem < 40'(BLOCK_BYTES)) ? LW'(rem) : LW'(BLOCK_BYTES);
    assign age      = now_reg - tm_rd_reg;
    assign in_block = 40'(off_reg) < (40'(start_d_reg) + 40'(BLOCK_BYTES));
    assign eval_en  = cmd.walk_en && valid_d_reg;

    always_comb begin
        ev_stop    = 1'b0;
        ev_wr      = 1'b0;
        ev_tm_wr   = 1'b0;
        ev_st      = pbst_pkg::BS_FREE;
        ev_tm      = '0;
        ev_status  = pbst_pkg::STS_NONE;
        ev_grant   = 1'b0;
        ev_allfull = 1'b0;
        case (type_reg)
            pbst_pkg::REQ_BLOCK: begin
                if (!exists_d_reg) begin
                    ev_stop = 1'b1;
                end else if (st_rd_reg == pbst_pkg::BS_FREE) begin
                    ev_stop   = 1'b1;
                    ev_wr     = 1'b1;
                    ev_tm_wr  = 1'b1;
                    ev_st     = pbst_pkg::BS_PENDING;
                    ev_tm     = now_reg;
                    ev_status = pbst_pkg::STS_DONE;
                    ev_grant  = 1'b1;
                end
            end
            pbst_pkg::REQ_ARRIVE: begin
                if (!exists_d_reg) begin
                    ev_stop   = 1'b1;
                    ev_status = pbst_pkg::STS_RANGE;
                end else if (in_block) begin
                    ev_stop = 1'b1;
                    if (!pd_rd_reg && (st_rd_reg != pbst_pkg::BS_FULL)) begin
                        ev_wr     = 1'b1;
                        ev_st     = pbst_pkg::BS_FULL;
                        ev_status = pbst_pkg::STS_DONE;
                    end
                end
            end
            pbst_pkg::REQ_SWEEP: begin
                if (!exists_d_reg) begin
                    ev_stop   = 1'b1;
                    ev_status = pbst_pkg::STS_DONE;
                end else if ((st_rd_reg == pbst_pkg::BS_PENDING) &&
                             (age > 32'(cfg.timeout_seconds))) begin
                    ev_wr    = 1'b1;
                    ev_tm_wr = 1'b1;
                end
            end
            pbst_pkg::REQ_ALLFULL: begin
                if (!exists_d_reg) begin
                    ev_stop    = 1'b1;
                    ev_status  = pbst_pkg::STS_DONE;
                    ev_allfull = 1'b1;
                end else if (st_rd_reg != pbst_pkg::BS_FULL) begin
                    ev_stop   = 1'b1;
                    ev_status = pbst_pkg::STS_DONE;
                end
            end
            pbst_pkg::REQ_FAIL: begin
                if (!exists_d_reg) begin
                    ev_stop = 1'b1;
                end else begin
                    ev_wr    = 1'b1;
                    ev_tm_wr = 1'b1;
                end
            end
            default: begin
                ev_stop = 1'b1;
            end
        endcase
    end

    // ---- clearing pass after reset ----
    assign clr_last = clr_cnt_reg == AW'(DEPTH - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_en && !clr_last) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // ---- table writes ----
    assign bs_we    = cmd.clr_en || (eval_en && ev_wr);
    assign bs_waddr = cmd.clr_en ? clr_cnt_reg : addr_d_reg;
    assign bs_wdata = cmd.clr_en ? pbst_pkg::BS_FREE : ev_st;

    always_ff @(posedge aclk) begin
        if (bs_we) begin
            bs_mem[bs_waddr] <= bs_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_en && ev_tm_wr) begin
            tm_mem[addr_d_reg] <= ev_tm;
        end
    end

    assign pd_we    = (cmd.clr_en && (32'(clr_cnt_reg) < 32'(NUM_PIECES))) || mark_done;
    assign pd_waddr = cmd.clr_en ? PW'(clr_cnt_reg) : p_idx;
    assign pd_wdata = !cmd.clr_en;

    always_ff @(posedge aclk) begin
        if (pd_we) begin
            pd_mem[pd_waddr] <= pd_wdata;
        end
    end

    // ---- result and output registers ----
    always_ff @(posedge aclk) begin
        if (cmd.early) begin
            res_status_reg  <= early_status;
            res_block_reg   <= '0;
            res_len_reg     <= '0;
            res_allfull_reg <= 1'b0;
        end else if (eval_en && ev_stop) begin
            res_status_reg  <= ev_status;
            res_block_reg   <= ev_grant ? 6'(i_d_reg) : 6'd0;
            res_len_reg     <= ev_grant ? 15'(blen) : 15'd0;
            res_allfull_reg <= ev_allfull;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_status_reg  <= res_status_reg;
            out_block_reg   <= res_block_reg;
            out_len_reg     <= res_len_reg;
            out_allfull_reg <= res_allfull_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_allfull_reg, out_len_reg, out_block_reg, out_status_reg};

    assign stat.clr_last  = clr_last;
    assign stat.early     = early;
    assign stat.walk_stop = eval_en && ev_stop;
    assign stat.out_busy  = m_tvalid_reg && !m_tready;

endmodule

`default_nettype wire
